// ===== rtl/icm_pkg.sv =====
// ----------------------------------------------------------------------------
// icm_pkg: shared constants, types and color table for the color map
// Sample and fraction widths, register indexes and the 13-entry RGB table
// used by the piecewise-linear interpolation.
// ----------------------------------------------------------------------------
package icm_pkg;

	// data widths
	localparam int SAMPLE_BITS   = 16;
	localparam int FRACTION_BITS = 8;

	// 12 segments between 13 table entries; quotient stays below 12 << F
	localparam int ROM_ENTRIES  = 13;
	localparam int SEGMENTS     = ROM_ENTRIES - 1;
	localparam int IDX_BITS     = 4;
	localparam int QUO_BITS     = FRACTION_BITS + IDX_BITS;
	localparam int SCALED_BITS  = SAMPLE_BITS + IDX_BITS;
	localparam int CHAN_BITS    = 8;
	localparam int SUM_BITS     = CHAN_BITS + FRACTION_BITS + 1;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_LOW  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_HIGH = 2'd1;

	localparam logic [SAMPLE_BITS-1:0] RANGE_LOW_RESET  = '0;
	localparam logic [SAMPLE_BITS-1:0] RANGE_HIGH_RESET = '1;

	localparam logic [CHAN_BITS-1:0] CHAN_FULL = '1;

	typedef struct packed {
		logic [CHAN_BITS-1:0] r;
		logic [CHAN_BITS-1:0] g;
		logic [CHAN_BITS-1:0] b;
	} color_t;

	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ROM_ENTRIES - 1);

	// color table, channels rounded from unit range to 8 bits
	function automatic color_t rom_color(input logic [IDX_BITS-1:0] idx);
		color_t c;
		case (idx)
			4'd0:    c = '{8'd77,  8'd77,  8'd77};
			4'd1:    c = '{8'd5,   8'd102, 8'd242};
			4'd2:    c = '{8'd33,  8'd23,  8'd181};
			4'd3:    c = '{8'd38,  8'd166, 8'd138};
			4'd4:    c = '{8'd18,  8'd156, 8'd105};
			4'd5:    c = '{8'd161, 8'd209, 8'd61};
			4'd6:    c = '{8'd252, 8'd179, 8'd46};
			4'd7:    c = '{8'd250, 8'd94,  8'd153};
			4'd8:    c = '{8'd252, 8'd48,  8'd97};
			4'd9:    c = '{8'd252, 8'd48,  8'd97};
			4'd10:   c = '{8'd219, 8'd41,  8'd51};
			4'd11:   c = '{8'd166, 8'd51,  8'd51};
			default: c = '{8'd153, 8'd10,  8'd15};
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/interpolated_color_map.sv =====
// ----------------------------------------------------------------------------
// interpolated_color_map: piecewise-linear intensity to RGBA color map
// Scales the sample into 12 table segments with a pipelined restoring
// divider, then blends neighboring table colors per channel.
// ----------------------------------------------------------------------------
// Pipeline: stage 1, stage 2 (divider entry 0), the divider stages, the product
// stage and the output stage; done and the color are registered together.
// Throughput: one sample per cycle; busy is always low, one divider stage per
// quotient bit keeps every stage at one compare and subtract.
// Reset: arst_n clears all valid bits and loads range_low = 0 and
// range_high = 65535; results cannot be stalled by the receiver.
module interpolated_color_map
	import icm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [SAMPLE_BITS-1:0]    sample,
	output logic                      done,
	output logic [CHAN_BITS-1:0]      red,
	output logic [CHAN_BITS-1:0]      green,
	output logic [CHAN_BITS-1:0]      blue,
	output logic [CHAN_BITS-1:0]      alpha,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]    cfg_data
);

	// configuration registers
	logic [SAMPLE_BITS-1:0] range_low_q;
	logic [SAMPLE_BITS-1:0] range_high_q;
	logic [SAMPLE_BITS-1:0] span_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// register write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RESET;
			range_high_q <= RANGE_HIGH_RESET;
			span_q       <= RANGE_HIGH_RESET - RANGE_LOW_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_RANGE_LOW:  range_low_q  <= cfg_data;
					CFG_RANGE_HIGH: range_high_q <= cfg_data;
					default: ;
				endcase
			end
			span_q <= range_high_q - range_low_q;
		end
	end

	// stage 1: range checks and offset from range_low
	logic                   valid_s1, white_s1, last_s1;
	logic [SAMPLE_BITS-1:0] offs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		white_s1 <= sample <= range_low_q;
		last_s1  <= sample >= range_high_q;
		offs_s1  <= sample - range_low_q;
	end

	// stage 2: scale by 12 and split dividend into head and shifted-in bits
	logic [SCALED_BITS-1:0] scaled;

	assign scaled = (SCALED_BITS'(offs_s1) << 3) + (SCALED_BITS'(offs_s1) << 2);

	// divider stages: one quotient bit per stage, entry 0 holds the stage 2 data
	logic                   div_valid_s [QUO_BITS+1];
	logic                   div_white_s [QUO_BITS+1];
	logic                   div_last_s  [QUO_BITS+1];
	logic [SAMPLE_BITS-1:0] div_rem_s   [QUO_BITS+1];
	logic [QUO_BITS-1:0]    div_low_s   [QUO_BITS];
	logic [QUO_BITS-1:0]    div_quo_s   [QUO_BITS+1];

	logic [SAMPLE_BITS-1:0] rem_next [QUO_BITS];
	logic [QUO_BITS-1:0]    quo_next [QUO_BITS];

	// restoring step: shift in one dividend bit, subtract span when it fits
	always_comb begin
		logic [SAMPLE_BITS:0] trial;
		logic                 fits;
		for (int k = 0; k < QUO_BITS; k++) begin
			trial = {div_rem_s[k], div_low_s[k][QUO_BITS-1]};
			fits  = trial >= {1'b0, span_q};
			rem_next[k] = fits ? SAMPLE_BITS'(trial - {1'b0, span_q})
			                   : trial[SAMPLE_BITS-1:0];
			quo_next[k] = {div_quo_s[k][QUO_BITS-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QUO_BITS; k++) begin
				div_valid_s[k] <= 1'b0;
			end
		end else begin
			div_valid_s[0] <= valid_s1;
			for (int k = 1; k <= QUO_BITS; k++) begin
				div_valid_s[k] <= div_valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		div_white_s[0] <= white_s1;
		div_last_s[0]  <= last_s1 && !white_s1;
		div_rem_s[0]   <= scaled[SCALED_BITS-1:IDX_BITS];
		div_low_s[0]   <= {scaled[IDX_BITS-1:0], {FRACTION_BITS{1'b0}}};
		div_quo_s[0]   <= '0;
		for (int k = 1; k <= QUO_BITS; k++) begin
			div_white_s[k] <= div_white_s[k-1];
			div_last_s[k]  <= div_last_s[k-1];
			div_rem_s[k]   <= rem_next[k-1];
			div_quo_s[k]   <= quo_next[k-1];
		end
		for (int k = 1; k < QUO_BITS; k++) begin
			div_low_s[k] <= div_low_s[k-1] << 1;
		end
	end

	// product stage: weighted sum of the two neighboring table colors
	logic [IDX_BITS-1:0]      seg_idx;
	logic [FRACTION_BITS-1:0] seg_frac;
	logic [FRACTION_BITS:0]   w_hi, w_lo;
	color_t                   col_a, col_b;

	assign seg_idx  = div_quo_s[QUO_BITS][QUO_BITS-1:FRACTION_BITS];
	assign seg_frac = div_quo_s[QUO_BITS][FRACTION_BITS-1:0];
	assign w_hi     = {1'b0, seg_frac};
	assign w_lo     = (FRACTION_BITS+1)'(1 << FRACTION_BITS) - w_hi;
	assign col_a    = rom_color(seg_idx);
	assign col_b    = rom_color(seg_idx + IDX_BITS'(1));

	logic                valid_mul_s, white_mul_s, last_mul_s;
	logic [SUM_BITS-1:0] sum_r_mul_s, sum_g_mul_s, sum_b_mul_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_mul_s <= 1'b0;
		end else begin
			valid_mul_s <= div_valid_s[QUO_BITS];
		end
	end

	always_ff @(posedge clk) begin
		white_mul_s <= div_white_s[QUO_BITS];
		last_mul_s  <= div_last_s[QUO_BITS];
		sum_r_mul_s <= SUM_BITS'(col_a.r * w_lo) + SUM_BITS'(col_b.r * w_hi);
		sum_g_mul_s <= SUM_BITS'(col_a.g * w_lo) + SUM_BITS'(col_b.g * w_hi);
		sum_b_mul_s <= SUM_BITS'(col_a.b * w_lo) + SUM_BITS'(col_b.b * w_hi);
	end

	// output stage: pick white, last color or blended color
	color_t last_col;
	logic   done_q;
	color_t out_q;

	assign last_col = rom_color(LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_mul_s;
		end
	end

	always_ff @(posedge clk) begin
		if (white_mul_s) begin
			out_q <= '{CHAN_FULL, CHAN_FULL, CHAN_FULL};
		end else if (last_mul_s) begin
			out_q <= last_col;
		end else begin
			out_q.r <= sum_r_mul_s[FRACTION_BITS +: CHAN_BITS];
			out_q.g <= sum_g_mul_s[FRACTION_BITS +: CHAN_BITS];
			out_q.b <= sum_b_mul_s[FRACTION_BITS +: CHAN_BITS];
		end
	end

	assign done  = done_q;
	assign red   = out_q.r;
	assign green = out_q.g;
	assign blue  = out_q.b;
	assign alpha = CHAN_FULL;

	// divider remainder stays below the span for in-range items
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid_s[QUO_BITS] && !div_white_s[QUO_BITS] && !div_last_s[QUO_BITS]
		|-> div_rem_s[QUO_BITS] < span_q)
		else $error("divider remainder not below span");

	// quotient for in-range items selects a real segment
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid_s[QUO_BITS] && !div_white_s[QUO_BITS] && !div_last_s[QUO_BITS]
		|-> seg_idx < IDX_BITS'(SEGMENTS))
		else $error("segment index out of range");

	// each item in the product stage produces a done transfer from the output stage
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		valid_mul_s |=> done)
		else $error("result lost between product and output stage");

endmodule
